// File: sv/utf8v_pkg.sv
// Package for the UTF-8 string validator: transaction payload types,
// decoder state type, status codes and code point limits.
// No dependencies.
package utf8v_pkg;

  localparam int unsigned ByteCountW = 17;
  localparam int unsigned CpW        = 21;

  typedef enum logic [1:0] {
    StatusValid     = 2'd0,
    StatusMalformed = 2'd1,
    StatusTooLong   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ByteCountW-1:0] byte_count;
  } out_t;

  typedef struct packed {
    logic [1:0]     pending;
    logic [2:0]     seq_len;
    logic [CpW-1:0] cp;
    logic           err;
  } dec_state_t;

  localparam logic [CpW-1:0] CpSurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] CpSurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] CpNonCharLo = 21'h00FDD0;
  localparam logic [CpW-1:0] CpNonCharHi = 21'h00FDEF;
  localparam logic [15:0]    CpPlaneFffe = 16'hFFFE;
  localparam logic [15:0]    CpPlaneFfff = 16'hFFFF;
  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0] CpMin3      = 21'h000800;
  localparam logic [CpW-1:0] CpMin4      = 21'h010000;
  localparam logic [CpW-1:0] CpC0Hi      = 21'h00001F;
  localparam logic [CpW-1:0] CpDel       = 21'h00007F;
  localparam logic [CpW-1:0] CpC1Hi      = 21'h00009F;

endpackage

// File: sv/utf8v_decoder.sv
// UTF-8 decoder step: next decoder state from the current state and one byte.
// Depends on utf8v_pkg.
module utf8v_decoder (
  input  utf8v_pkg::dec_state_t st_i,
  input  logic [7:0]            byte_i,
  output utf8v_pkg::dec_state_t st_o
);

  function automatic logic cp_bad(logic [utf8v_pkg::CpW-1:0] cp, logic [2:0] len);
    logic bad;
    bad = 1'b0;
    if (cp >= utf8v_pkg::CpSurrLo && cp <= utf8v_pkg::CpSurrHi) bad = 1'b1;
    if (len == 3'd3 && cp < utf8v_pkg::CpMin3) bad = 1'b1;
    if (len == 3'd4 && (cp < utf8v_pkg::CpMin4 || cp > utf8v_pkg::CpMax)) bad = 1'b1;
    if (cp >= utf8v_pkg::CpNonCharLo && cp <= utf8v_pkg::CpNonCharHi) bad = 1'b1;
    if (cp[15:0] == utf8v_pkg::CpPlaneFffe || cp[15:0] == utf8v_pkg::CpPlaneFfff) begin
      bad = 1'b1;
    end
    if (cp <= utf8v_pkg::CpC0Hi || (cp >= utf8v_pkg::CpDel && cp <= utf8v_pkg::CpC1Hi)) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

  logic [utf8v_pkg::CpW-1:0] cont_cp;
  logic [1:0]                cont_pending;

  assign cont_cp      = {st_i.cp[utf8v_pkg::CpW-7:0], byte_i[5:0]};
  assign cont_pending = st_i.pending - 2'd1;

  always_comb begin
    st_o = st_i;
    if (!st_i.err) begin
      if (st_i.pending == 2'd0) begin
        if (byte_i == 8'h00) begin
          st_o.err = 1'b1;
        end else if (byte_i[7] == 1'b0) begin
          st_o.seq_len = 3'd1;
          st_o.cp      = utf8v_pkg::CpW'(byte_i);
          st_o.err     = cp_bad(utf8v_pkg::CpW'(byte_i), 3'd1);
        end else if (byte_i[7:5] == 3'b110) begin
          if (byte_i[4:1] == 4'b0000) begin
            st_o.err = 1'b1;
          end else begin
            st_o.seq_len = 3'd2;
            st_o.pending = 2'd1;
            st_o.cp      = utf8v_pkg::CpW'(byte_i[4:0]);
          end
        end else if (byte_i[7:4] == 4'b1110) begin
          st_o.seq_len = 3'd3;
          st_o.pending = 2'd2;
          st_o.cp      = utf8v_pkg::CpW'(byte_i[3:0]);
        end else if (byte_i[7:3] == 5'b11110 && byte_i <= 8'hF4) begin
          st_o.seq_len = 3'd4;
          st_o.pending = 2'd3;
          st_o.cp      = utf8v_pkg::CpW'(byte_i[2:0]);
        end else begin
          st_o.err = 1'b1;
        end
      end else begin
        if (byte_i[7:6] != 2'b10) begin
          st_o.err     = 1'b1;
          st_o.pending = 2'd0;
        end else begin
          st_o.cp      = cont_cp;
          st_o.pending = cont_pending;
          if (cont_pending == 2'd0 && cp_bad(cont_cp, st_i.seq_len)) begin
            st_o.err = 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: sv/utf8_string_validator.sv
// Top level of the UTF-8 string validator: input register, decoder state,
// byte counter and result register. Depends on utf8v_pkg and utf8v_decoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid_i/in_ready_o  | in_data_i  (data_byte, last_byte)
//  out      | out_valid_o/out_ready_i| out_data_o (status, byte_count)
//
// One byte per cycle sustained while no final byte waits on the result register;
// decode and count update run while a byte sits in the input register, and a
// final byte's result is then loaded into the result register.
// Reset clears decoder state, byte count and both valid flags.
// Input stalls only when a final byte waits on a full, stalled result register.
module utf8_string_validator #(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  utf8v_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output utf8v_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_STRING_BYTES + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_STRING_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_STRING_BYTES);

  logic                  in_valid_q;
  utf8v_pkg::in_t        in_q;
  utf8v_pkg::dec_state_t st_q, st_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q;
  utf8v_pkg::out_t       out_q, out_d;
  logic                  out_free;
  logic                  advance;

  utf8v_decoder u_decoder (
    .st_i   (st_q),
    .byte_i (in_q.data_byte),
    .st_o   (st_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!in_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign cnt_d      = (cnt_q < CntSat) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    out_d.byte_count = utf8v_pkg::ByteCountW'(cnt_d);
    if (cnt_d > CntMax) begin
      out_d.status = utf8v_pkg::StatusTooLong;
    end else if (st_d.err || st_d.pending != 2'd0) begin
      out_d.status = utf8v_pkg::StatusMalformed;
    end else begin
      out_d.status = utf8v_pkg::StatusValid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        if (in_q.last_byte) begin
          st_q  <= '0;
          cnt_q <= '0;
        end else begin
          st_q  <= st_d;
          cnt_q <= cnt_d;
        end
      end
      if (advance && in_q.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && in_q.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last_byte |=> cnt_q == '0 && st_q == '0)
    else $error("state not cleared after final byte");

  a_too_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == utf8v_pkg::StatusTooLong
      |-> 32'(out_data_o.byte_count) > MAX_STRING_BYTES)
    else $error("too-long status with short count");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && in_q.last_byte && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked final byte");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pending != 2'd0 |-> 3'(st_q.pending) < st_q.seq_len)
    else $error("pending continuations disagree with sequence length");

endmodule

// File: tb/sv/tb_utf8_string_validator.sv
// Self-checking testbench for utf8_string_validator: a byte-level UTF-8 tracker
// predicts status and byte count per string, checked against every result.
// Depends on utf8v_pkg and the utf8_string_validator RTL.
module tb_utf8_string_validator;

  localparam int unsigned MaxBytes      = 65536;
  localparam int          HoldCycles    = 200;
  localparam int          WatchdogLimit = 2000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  utf8v_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  utf8v_pkg::out_t out_data;

  logic idle_on = 1'b1;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   n_fail = 0;
  int   bytes_sent = 0;

  logic [1:0]                       pend_cont = '0;
  logic [2:0]                       seq_len = '0;
  logic [utf8v_pkg::CpW-1:0]        cp_acc = '0;
  logic                             err_seen = 1'b0;
  logic [utf8v_pkg::ByteCountW-1:0] nbytes = '0;
  utf8v_pkg::out_t                  predicted_verdicts[$];

  utf8_string_validator #(.MAX_STRING_BYTES(MaxBytes)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit cp_rejected(logic [utf8v_pkg::CpW-1:0] cp, logic [2:0] len);
    return (cp >= utf8v_pkg::CpSurrLo && cp <= utf8v_pkg::CpSurrHi)
        || (len == 3'd3 && cp < utf8v_pkg::CpMin3)
        || (len == 3'd4 && (cp < utf8v_pkg::CpMin4 || cp > utf8v_pkg::CpMax))
        || (cp >= utf8v_pkg::CpNonCharLo && cp <= utf8v_pkg::CpNonCharHi)
        || cp[15:0] == utf8v_pkg::CpPlaneFffe || cp[15:0] == utf8v_pkg::CpPlaneFfff
        || cp <= utf8v_pkg::CpC0Hi
        || (cp >= utf8v_pkg::CpDel && cp <= utf8v_pkg::CpC1Hi);
  endfunction

  task automatic track_utf8_byte(input utf8v_pkg::in_t t);
    logic [7:0]      b;
    utf8v_pkg::out_t verdict;
    b = t.data_byte;
    if (nbytes < MaxBytes + 1) nbytes = nbytes + 1'b1;
    if (!err_seen) begin
      if (pend_cont == 2'd0) begin
        if (b == 8'h00) begin
          err_seen = 1'b1;
        end else if (b <= 8'h7F) begin
          seq_len = 3'd1;
          cp_acc  = {13'd0, b};
          if (cp_rejected(cp_acc, 3'd1)) err_seen = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          if (b == 8'hC0 || b == 8'hC1) begin
            err_seen = 1'b1;
          end else begin
            seq_len   = 3'd2;
            pend_cont = 2'd1;
            cp_acc    = {16'd0, b[4:0]};
          end
        end else if (b[7:4] == 4'b1110) begin
          seq_len   = 3'd3;
          pend_cont = 2'd2;
          cp_acc    = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
          seq_len   = 3'd4;
          pend_cont = 2'd3;
          cp_acc    = {18'd0, b[2:0]};
        end else begin
          err_seen = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        err_seen  = 1'b1;
        pend_cont = 2'd0;
      end else begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        pend_cont = pend_cont - 2'd1;
        if (pend_cont == 2'd0 && cp_rejected(cp_acc, seq_len)) err_seen = 1'b1;
      end
    end
    if (t.last_byte) begin
      if (nbytes > MaxBytes) verdict.status = utf8v_pkg::StatusTooLong;
      else if (err_seen || pend_cont != 2'd0) verdict.status = utf8v_pkg::StatusMalformed;
      else verdict.status = utf8v_pkg::StatusValid;
      verdict.byte_count = nbytes;
      predicted_verdicts.push_back(verdict);
      pend_cont = '0;
      seq_len   = '0;
      cp_acc    = '0;
      err_seen  = 1'b0;
      nbytes    = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    utf8v_pkg::in_t t;
    t.data_byte = b;
    t.last_byte = last;
    while (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_utf8_byte(t);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  function automatic void add_char(ref logic [7:0] q[$]);
    int                        len;
    int                        sel;
    logic [utf8v_pkg::CpW-1:0] cp;
    len = $urandom_range(1, 4);
    sel = $urandom_range(99);
    case (len)
      1: cp = utf8v_pkg::CpW'($urandom_range(0, 'h7F));
      2: cp = (sel < 10) ? utf8v_pkg::CpW'($urandom_range(0, 'h7F))
                         : utf8v_pkg::CpW'($urandom_range('h80, 'h7FF));
      3: begin
        if (sel < 10) begin
          cp = utf8v_pkg::CpW'($urandom_range(0, 'h7FF));
        end else if (sel < 30) begin
          case ($urandom_range(0, 2))
            0: cp = utf8v_pkg::CpSurrLo + utf8v_pkg::CpW'($urandom_range(0, 'h7FF));
            1: cp = utf8v_pkg::CpNonCharLo + utf8v_pkg::CpW'($urandom_range(0, 31));
            default: cp = {5'd0, 15'h7FFF, 1'($urandom_range(0, 1))};
          endcase
        end else begin
          cp = utf8v_pkg::CpW'($urandom_range('h800, 'hFFFF));
        end
      end
      default: begin
        if (sel < 8) cp = utf8v_pkg::CpW'($urandom_range(0, 'hFFFF));
        else if (sel < 16) cp = utf8v_pkg::CpW'($urandom_range('h110000, 'h1FFFFF));
        else if (sel < 30) cp = {5'($urandom_range(1, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
        else cp = utf8v_pkg::CpW'($urandom_range('h10000, 'h10FFFF));
      end
    endcase
    case (len)
      1: q.push_back({1'b0, cp[6:0]});
      2: begin
        q.push_back({3'b110, cp[10:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        q.push_back({4'b1110, cp[15:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        q.push_back({5'b11110, cp[20:18]});
        q.push_back({2'b10, cp[17:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  task automatic send_random_string();
    logic [7:0] s[$];
    int         kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) add_char(s);
      if (kind < 18 && s.size() > 1) s.pop_back();
      else if (kind < 26) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    end
    send_string(s);
  endtask

  task automatic test_directed();
    logic [7:0] s[$];
    s = '{8'h00};                      send_string(s);
    s = '{8'hFF};                      send_string(s);
    s = '{8'hC1};                      send_string(s);
    s = '{8'h7F};                      send_string(s);
    s = '{8'h80, 8'h41};               send_string(s);
    s = '{8'hE2, 8'h82};               send_string(s);
    s = '{8'hED, 8'hA0, 8'h80};        send_string(s);
    s = '{8'hE0, 8'h9F, 8'hBF};        send_string(s);
    s = '{8'hF0, 8'h8F, 8'hBF, 8'hBF}; send_string(s);
    s = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string(s);
    s = '{8'hEF, 8'hB7, 8'h90};        send_string(s);
    s = '{8'hEF, 8'hBF, 8'hBE};        send_string(s);
    s = '{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80}; send_string(s);
  endtask

  task automatic test_random_strings();
    int stop_at;
    stop_at = bytes_sent + 750;
    while (bytes_sent < stop_at) send_random_string();
  endtask

  task automatic test_no_idle();
    int stop_at;
    idle_on <= 1'b0;
    stop_at = bytes_sent + 150;
    while (bytes_sent < stop_at) send_random_string();
    idle_on <= 1'b1;
  endtask

  task automatic test_output_stall();
    hold_go <= ~hold_go;
    repeat (30) send_byte(8'($urandom_range('h20, 'h7E)), 1'b1);
    repeat (20) send_random_string();
  endtask

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin : result_check
    utf8v_pkg::out_t got;
    utf8v_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (predicted_verdicts.size() == 0) begin
        $error("unpredicted transaction: status %0d byte_count %0d", got.status,
               got.byte_count);
        n_fail++;
      end else begin
        want = predicted_verdicts.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          n_fail++;
        end
        if (got.byte_count != want.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_strings();
    test_no_idle();
    test_output_stall();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
